// ----- hdl/epr3_pkg.sv -----
// Package for the 3D Euler point rotation pipeline.
// Holds the Q30 format constants, sine polynomial coefficients and rounding helpers.
// No dependencies.
package epr3_pkg;

   localparam int QF = 30;
   localparam int SPLIT = 24;
   localparam logic signed [32:0] Q_ONE = 33'sd1073741824;
   localparam logic signed [63:0] Q_HALF = 64'sd536870912;

   localparam int N_COEF = 6;
   localparam logic signed [32:0] K11 = 33'sd3864;
   localparam logic signed [32:0] K9 = 33'sd172272;
   localparam logic signed [32:0] K7 = 33'sd5026995;
   localparam logic signed [32:0] K5 = 33'sd85569306;
   localparam logic signed [32:0] K3 = 33'sd693598669;
   localparam logic signed [32:0] K1 = 33'sd1686629713;

   typedef logic signed [32:0] q30_type;

   // Coefficient subtracted at Horner step k (k = 0 uses K9).
   function automatic q30_type coef(input logic [2:0] k);
      q30_type c;
      c = K1;
      unique case (k)
         3'd0: c = K9;
         3'd1: c = K7;
         3'd2: c = K5;
         3'd3: c = K3;
         3'd4: c = K1;
         default: c = K1;
      endcase
      return c;
   endfunction

   // Q30 product rounded to nearest, ties toward plus infinity.
   function automatic q30_type qmul(input q30_type a, input q30_type b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b) + 66'(Q_HALF);
      return q30_type'(p >>> QF);
   endfunction

endpackage

// ----- hdl/epr3_sine_cell.sv -----
// One Horner step cell of the sine chain: t_out = coef - u2 * t_in.
// Depends on epr3_pkg. Passes u, u2 and the flag bits (quadrant sign, endpoint mark) to its neighbor.
module epr3_sine_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              enable,
   input  epr3_pkg::q30_type u_in,
   input  epr3_pkg::q30_type u2_in,
   input  epr3_pkg::q30_type t_in,
   input  logic [1:0]        flag_in,
   output epr3_pkg::q30_type u_out,
   output epr3_pkg::q30_type u2_out,
   output epr3_pkg::q30_type t_out,
   output logic [1:0]        flag_out
);
   epr3_pkg::q30_type t_ff, u_ff, u2_ff;
   logic [1:0] flag_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff <= epr3_pkg::coef(3'(STEP)) - epr3_pkg::qmul(u2_in, t_in);
         u_ff <= u_in;
         u2_ff <= u2_in;
         flag_ff <= flag_in;
      end
   end

   assign t_out = t_ff;
   assign u_out = u_ff;
   assign u2_out = u2_ff;
   assign flag_out = flag_ff;
endmodule

// ----- hdl/epr3_sine.sv -----
// Pipelined turn sine: quadrant fold, u squared, a chain of Horner cells, final scale.
// Depends on epr3_pkg and epr3_sine_cell.
module epr3_sine #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ANGLE_BITS-1:0] angle,
   output epr3_pkg::q30_type     sine
);
   localparam int NC = epr3_pkg::N_COEF - 1;
   logic [1:0] q;
   logic [29:0] u_w;
   epr3_pkg::q30_type u0_ff, u1_ff, u2_1_ff, s_ff, fin;
   logic [1:0] f0_ff, f1_ff, fs_ff;
   epr3_pkg::q30_type cu[NC+1], cu2[NC+1], ct[NC+1];
   logic [1:0] cf[NC+1];

   assign q = angle[ANGLE_BITS-1 -: 2];
   assign u_w = 30'(angle[ANGLE_BITS-3:0]) << (30 - (ANGLE_BITS - 2));

   always_ff @(posedge clock) begin
      if (enable) begin
         u0_ff <= q[0] ? epr3_pkg::Q_ONE - 33'(u_w) : 33'(u_w);
         f0_ff <= {q[1], 1'b0};
         u1_ff <= u0_ff;
         u2_1_ff <= epr3_pkg::qmul(u0_ff, u0_ff);
         // Flag bit 0 marks the exact endpoints, where the sine is forced.
         f1_ff <= {f0_ff[1], (u0_ff == 33'sd0) || (u0_ff == epr3_pkg::Q_ONE)};
      end
   end

   assign cu[0] = u1_ff;
   assign cu2[0] = u2_1_ff;
   assign ct[0] = epr3_pkg::K11;
   assign cf[0] = f1_ff;

   for (genvar k = 0; k < NC; k++) begin : g_cell
      epr3_sine_cell #(.STEP(k)) u_cell (
         .clock(clock), .enable(enable), .u_in(cu[k]), .u2_in(cu2[k]), .t_in(ct[k]),
         .flag_in(cf[k]), .u_out(cu[k+1]), .u2_out(cu2[k+1]), .t_out(ct[k+1]),
         .flag_out(cf[k+1])
      );
   end

   always_comb begin
      fin = epr3_pkg::qmul(cu[NC], ct[NC]);
      if (cf[NC][0]) begin
         fin = cu[NC];
      end else if (fin < 33'sd0) begin
         fin = 33'sd0;
      end else if (fin > epr3_pkg::Q_ONE) begin
         fin = epr3_pkg::Q_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s_ff <= fin;
         fs_ff <= cf[NC];
      end
   end

   assign sine = fs_ff[1] ? -s_ff : s_ff;
endmodule

// ----- hdl/euler_point_rotate_3d.sv -----
// Top level of the 3D Euler point rotation pipeline.
// Depends on epr3_pkg and epr3_sine. Builds M = A*(B*C) and applies it to the point.
//
// channel  dir  tdata fields (low bit first)
// req      in   px, py, pz, angle_a, angle_b, angle_c
// rsp      out  rx, ry, rz
//
// One transaction per cycle while the pipeline is not stalled; results pass through the sine chain and matrix stages.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears the valid bits of all stages; payload registers are not reset.
module euler_point_rotate_3d #(
   parameter int COORD_BITS = 32,
   parameter int ANGLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // px, py, pz, angle_a, angle_b, angle_c
   input  logic [((3*COORD_BITS+3*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rx, ry, rz
   output logic [((3*COORD_BITS+7)/8)*8-1:0] rsp_tdata
);
   localparam int LAT = 13;
   localparam int SD = 10;
   localparam int OW = ((3*COORD_BITS+7)/8)*8;
   localparam int SPL = epr3_pkg::SPLIT;
   localparam int HW = (COORD_BITS > SPL) ? COORD_BITS - SPL : 1;
   localparam int AW = 33 + HW + 3;
   localparam int LW = 33 + SPL + 3;
   typedef logic signed [32:0] q_type;

   logic adv;
   logic [LAT-1:0] vld_ff;
   logic [3*COORD_BITS-1:0] pts_ff[SD];
   logic [ANGLE_BITS-1:0] ang[6];
   q_type sn[6];
   q_type p2_m[9];
   q_type t_sa_sb_ff, t_ca_sb_ff, sa_ff, ca_ff, sb_ff, cb_ff, sc_ff, cc_ff;
   q_type m_ff[9];
   logic signed [COORD_BITS-1:0] p_px, p_py, p_pz;
   logic signed [AW-1:0] hi_ff[3];
   logic signed [LW-1:0] lo_ff[3];
   logic signed [AW-1:0] v_w[3];
   logic signed [COORD_BITS-1:0] r_ff[3];
   logic [3*COORD_BITS-1:0] ptail_ff;

   assign rsp_tvalid = vld_ff[LAT-1];
   assign adv = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;

   assign ang[0] = req_tdata[3*COORD_BITS +: ANGLE_BITS];
   assign ang[1] = req_tdata[3*COORD_BITS+ANGLE_BITS +: ANGLE_BITS];
   assign ang[2] = req_tdata[3*COORD_BITS+2*ANGLE_BITS +: ANGLE_BITS];
   assign ang[3] = ang[0] + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
   assign ang[4] = ang[1] + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
   assign ang[5] = ang[2] + ANGLE_BITS'(1 << (ANGLE_BITS - 2));

   // The sine units stall together with the rest of the pipeline.
   logic [ANGLE_BITS-1:0] ang_ff[6];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            ang_ff[i] <= ang[i];
         end
      end
   end

   for (genvar i = 0; i < 6; i++) begin : g_sin
      epr3_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
         .clock(clock), .enable(adv), .angle(ang_ff[i]), .sine(sn[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pts_ff[0] <= req_tdata[3*COORD_BITS-1:0];
         for (int i = 1; i < SD; i++) begin
            pts_ff[i] <= pts_ff[i-1];
         end
      end
   end

   // Matrix stage one: the shared partial products.
   always_ff @(posedge clock) begin
      if (adv) begin
         t_sa_sb_ff <= epr3_pkg::qmul(sn[0], sn[1]);
         t_ca_sb_ff <= epr3_pkg::qmul(sn[3], sn[1]);
         sa_ff <= sn[0];
         ca_ff <= sn[3];
         sb_ff <= sn[1];
         cb_ff <= sn[4];
         sc_ff <= sn[2];
         cc_ff <= sn[5];
      end
   end

   always_comb begin
      p2_m[0] = epr3_pkg::qmul(ca_ff, cc_ff) - epr3_pkg::qmul(t_sa_sb_ff, sc_ff);
      p2_m[1] = -epr3_pkg::qmul(sa_ff, cb_ff);
      p2_m[2] = epr3_pkg::qmul(ca_ff, sc_ff) + epr3_pkg::qmul(t_sa_sb_ff, cc_ff);
      p2_m[3] = epr3_pkg::qmul(sa_ff, cc_ff) + epr3_pkg::qmul(t_ca_sb_ff, sc_ff);
      p2_m[4] = epr3_pkg::qmul(ca_ff, cb_ff);
      p2_m[5] = epr3_pkg::qmul(sa_ff, sc_ff) - epr3_pkg::qmul(t_ca_sb_ff, cc_ff);
      p2_m[6] = -epr3_pkg::qmul(cb_ff, sc_ff);
      p2_m[7] = sb_ff;
      p2_m[8] = epr3_pkg::qmul(cb_ff, cc_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= p2_m;
         ptail_ff <= pts_ff[SD-1];
      end
   end

   assign p_px = ptail_ff[0 +: COORD_BITS];
   assign p_py = ptail_ff[COORD_BITS +: COORD_BITS];
   assign p_pz = ptail_ff[2*COORD_BITS +: COORD_BITS];

   function automatic logic signed [AW-1:0] hprod(input q_type m, input logic signed [COORD_BITS-1:0] p);
      logic signed [HW-1:0] ph;
      ph = HW'(p >>> SPL);
      return AW'(m) * AW'(ph);
   endfunction

   function automatic logic signed [LW-1:0] lprod(input q_type m, input logic signed [COORD_BITS-1:0] p);
      logic signed [SPL:0] pl;
      pl = {1'b0, SPL'(p)};
      return LW'(m) * LW'(pl);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            hi_ff[r] <= hprod(m_ff[3*r], p_px) + hprod(m_ff[3*r+1], p_py)
                      + hprod(m_ff[3*r+2], p_pz);
            lo_ff[r] <= lprod(m_ff[3*r], p_px) + lprod(m_ff[3*r+1], p_py)
                      + lprod(m_ff[3*r+2], p_pz) + LW'(epr3_pkg::Q_HALF);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         v_w[r] = (hi_ff[r] + AW'(lo_ff[r] >>> SPL)) >>> (epr3_pkg::QF - SPL);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            if (v_w[r] > AW'((64'sd1 <<< (COORD_BITS - 1)) - 1)) begin
               r_ff[r] <= {1'b0, {(COORD_BITS-1){1'b1}}};
            end else if (v_w[r] < -AW'(64'sd1 <<< (COORD_BITS - 1))) begin
               r_ff[r] <= {1'b1, {(COORD_BITS-1){1'b0}}};
            end else begin
               r_ff[r] <= COORD_BITS'(v_w[r]);
            end
         end
      end
   end

   assign rsp_tdata = OW'({r_ff[2], r_ff[1], r_ff[0]});

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted transaction lost");
endmodule
